// ----- design/oll_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package oll_pkg;

    // Value width of one list entry.
    localparam int ValueWidth = 32;
    // Width of the element count reported with every result.
    localparam int CountOutWidth = 5;
    // Result bus width: status and count packed, padded to whole bytes.
    localparam int ResultBusWidth = 8;

    typedef enum logic {
        ACT_APPEND = 1'b0,
        ACT_REMOVE = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        STS_APPENDED  = 2'd0,
        STS_REMOVED   = 2'd1,
        STS_NOT_FOUND = 2'd2,
        STS_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_DONE
    } state_t;

    // Finished result handed from the engine to the output stage.
    typedef struct packed {
        status_t                  status;
        logic [CountOutWidth-1:0] count_after;
    } result_t;

endpackage

`default_nettype wire

// ----- design/oll_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module oll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// ----- design/oll_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Sequencer that appends at the tail, or searches the entry memory from the
// head and closes the gap behind a matching entry.
module oll_engine #(
    parameter int CAPACITY = 16
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire oll_pkg::action_t                   in_action,
    input  wire logic [oll_pkg::ValueWidth-1:0]     in_value,
    output logic                                    res_valid,
    input  wire logic                               res_take,
    output oll_pkg::result_t                        res
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    oll_pkg::state_t  state_reg, state_next;
    oll_pkg::status_t status_reg, status_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic [oll_pkg::ValueWidth-1:0] value_reg, value_next;

    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [oll_pkg::ValueWidth-1:0] ram_wdata;
    logic [AW-1:0]                  ram_raddr;
    logic [oll_pkg::ValueWidth-1:0] ram_rdata;

    logic [CW-1:0] idx_ext;
    logic [CW-1:0] idx_inc;
    logic          at_last;
    logic          is_full;
    logic          is_match;

    assign idx_ext  = CW'(idx_reg);
    assign idx_inc  = idx_ext + CW'(1);
    assign at_last  = (idx_inc == count_reg);
    assign is_full  = (count_reg == CW'(CAPACITY));
    assign is_match = (ram_rdata == value_reg);

    oll_ram #(
        .WIDTH(oll_pkg::ValueWidth),
        .DEPTH(CAPACITY)
    ) u_entry_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            oll_pkg::ST_IDLE: begin
                if (in_valid) begin
                    if (in_action == oll_pkg::ACT_REMOVE && count_reg != '0) begin
                        state_next = oll_pkg::ST_SEARCH;
                    end else begin
                        state_next = oll_pkg::ST_DONE;
                    end
                end
            end
            oll_pkg::ST_SEARCH: begin
                if (is_match) begin
                    state_next = oll_pkg::ST_SHIFT;
                end else if (at_last) begin
                    state_next = oll_pkg::ST_DONE;
                end
            end
            oll_pkg::ST_SHIFT: begin
                if (at_last) begin
                    state_next = oll_pkg::ST_DONE;
                end
            end
            oll_pkg::ST_DONE: begin
                if (res_take) begin
                    state_next = oll_pkg::ST_IDLE;
                end
            end
            default: state_next = oll_pkg::ST_IDLE;
        endcase
    end

    // The read address always runs one entry ahead of the data being
    // examined, so a search or a shift moves one entry per cycle.
    always_comb begin
        count_next  = count_reg;
        idx_next    = idx_reg;
        value_next  = value_reg;
        status_next = status_reg;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg;
        ram_wdata   = ram_rdata;
        ram_raddr   = AW'(idx_inc);
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        unique case (state_reg)
            oll_pkg::ST_IDLE: begin
                in_ready  = 1'b1;
                ram_raddr = '0;
                if (in_valid) begin
                    value_next = in_value;
                    idx_next   = '0;
                    if (in_action == oll_pkg::ACT_APPEND) begin
                        if (is_full) begin
                            status_next = oll_pkg::STS_FULL;
                        end else begin
                            ram_we      = 1'b1;
                            ram_waddr   = AW'(count_reg);
                            ram_wdata   = in_value;
                            count_next  = count_reg + CW'(1);
                            status_next = oll_pkg::STS_APPENDED;
                        end
                    end else if (count_reg == '0) begin
                        status_next = oll_pkg::STS_NOT_FOUND;
                    end
                end
            end
            oll_pkg::ST_SEARCH: begin
                if (!is_match) begin
                    if (at_last) begin
                        status_next = oll_pkg::STS_NOT_FOUND;
                    end else begin
                        idx_next = AW'(idx_inc);
                    end
                end
            end
            oll_pkg::ST_SHIFT: begin
                if (at_last) begin
                    count_next  = count_reg - CW'(1);
                    status_next = oll_pkg::STS_REMOVED;
                end else begin
                    ram_we    = 1'b1;
                    ram_raddr = AW'(idx_ext + CW'(2));
                    idx_next  = AW'(idx_inc);
                end
            end
            oll_pkg::ST_DONE: begin
                res_valid = 1'b1;
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    assign res.status      = status_reg;
    assign res.count_after = oll_pkg::CountOutWidth'(count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= oll_pkg::ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        idx_reg    <= idx_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

endmodule

`default_nettype wire

// ----- design/ordered_list_append_remove.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Ports     | Content (lowest bit first)
// ----------+-----------+-----------------------------------------------------
// request   | s_tdata   | value[31:0] (signed)
//           | s_tuser   | action[0] (0 append, 1 remove)
// result    | m_tdata   | status[1:0], count_after[6:2], zero pad [7]
//
// An append, a refused append and a remove from an empty list go straight to
// the finished state after acceptance. A remove searches from the head,
// reading one entry per cycle from the single read port of the entry memory;
// on a match at position k it then shifts the entries behind it one per cycle
// toward the head. A remove that finds nothing reads all count entries. The
// next request is accepted after the sequencer has handed its result on.
// A new request is accepted only while the sequencer is idle; a finished
// result may still wait in the output register, and the sequencer then holds
// its own result until that register is taken. Reset (aresetn low on a clock
// edge) empties the list; the memory contents need no clearing.
module ordered_list_append_remove #(
    parameter int CAPACITY = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // value[31:0]
    input  wire logic        s_tuser,   // action[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // status[1:0], count_after[6:2], pad[7]
);

    logic              res_valid;
    logic              res_take;
    oll_pkg::result_t  res;

    logic              out_valid_reg, out_valid_next;
    oll_pkg::result_t  out_res_reg, out_res_next;

    // The engine does all the list work; this level adds the output register,
    // in which one result can wait while the engine takes the next request.
    oll_engine #(
        .CAPACITY(CAPACITY)
    ) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_action(oll_pkg::action_t'(s_tuser)),
        .in_value (s_tdata),
        .res_valid(res_valid),
        .res_take (res_take),
        .res      (res)
    );

    // A result moves into the output register when that register is empty
    // or is being emptied in the same cycle.
    assign res_take = res_valid && (!out_valid_reg || m_tready);

    always_comb begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_take) begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_res_reg.count_after, out_res_reg.status};

endmodule

`default_nettype wire
